// File: hw/rtl/sfir_pkg.sv
// Package for the symmetric FIR filter: word types, sequencer states and constants.
// Used by sfir_ctl, sfir_mac and the top level; has no dependencies of its own.
package sfir_pkg;

    localparam int unsigned NCOEF        = 8;
    localparam int unsigned COEF_W       = 16;
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned ACC_W        = 32;
    localparam int unsigned SLOT_W       = 4;
    localparam int unsigned STEP_W       = 3;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned TAPS_DEF     = 16;
    localparam int unsigned CHANNELS_DEF = 2;

    typedef struct packed {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic                       out_channel;
        logic signed [SAMPLE_W-1:0] filtered;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              middle;
        logic              last;
        logic              va;
        logic              vb;
        logic [STEP_W-1:0] k;
    } t_step;

    function automatic logic signed [COEF_W-1:0] coef_reset(input int unsigned idx);
        logic signed [COEF_W-1:0] v;
        case (idx)
            0: v = 16'sd0;
            1: v = 16'sd12;
            2: v = -16'sd108;
            3: v = -16'sd708;
            4: v = -16'sd924;
            5: v = 16'sd2588;
            6: v = 16'sd11568;
            7: v = 16'sd20336;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/sfir_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// No dependencies.
module sfir_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hw/rtl/sfir_ctl.sv
// Sequencer: input handshake, circular delay-line pointers and fill counts,
// RAM addressing and the per-pair step stream. Depends on sfir_pkg.
module sfir_ctl #(
    parameter int unsigned TAPS     = sfir_pkg::TAPS_DEF,
    parameter int unsigned CHANNELS = sfir_pkg::CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_channel,
    input  logic                               i_out_free,
    input  logic                               i_done,
    output logic                               o_load,
    output logic                               o_we,
    output logic [$clog2(CHANNELS*16)-1:0]     o_waddr,
    output logic [$clog2(CHANNELS*16)-1:0]     o_raddr_a,
    output logic [$clog2(CHANNELS*16)-1:0]     o_raddr_b,
    output sfir_pkg::t_step                    o_step
);

    localparam int unsigned ADDR_W = $clog2(CHANNELS * 16);
    localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned HALF   = (TAPS + 1) / 2;
    localparam bit          ODD    = (TAPS % 2) == 1;
    localparam bit          MULTI  = CHANNELS > 1;
    localparam logic [sfir_pkg::SLOT_W-1:0] OLDEST = sfir_pkg::SLOT_W'(TAPS - 1);
    localparam logic [sfir_pkg::STEP_W-1:0] LAST_K = sfir_pkg::STEP_W'(HALF - 1);

    sfir_pkg::t_state r_state, n_state;
    logic [sfir_pkg::STEP_W-1:0] r_k;
    logic                        r_ch;
    logic [sfir_pkg::SLOT_W-1:0] r_ptr  [CHANNELS];
    logic [sfir_pkg::SLOT_W-1:0] r_fill [CHANNELS];

    logic                        accept;
    logic                        in_ch;
    logic [CH_W-1:0]             in_idx;
    logic [CH_W-1:0]             run_idx;
    logic [sfir_pkg::SLOT_W-1:0] age_a;
    logic [sfir_pkg::SLOT_W-1:0] age_b;
    logic [sfir_pkg::SLOT_W-1:0] slot_a;
    logic [sfir_pkg::SLOT_W-1:0] slot_b;

    assign accept  = i_valid && o_ready;
    assign in_ch   = i_channel & MULTI;
    assign in_idx  = CH_W'(in_ch);
    assign run_idx = CH_W'(r_ch);

    assign age_a  = {1'b0, r_k};
    assign age_b  = OLDEST - {1'b0, r_k};
    assign slot_a = r_ptr[run_idx] - age_a;
    assign slot_b = r_ptr[run_idx] - age_b;

    assign o_we      = accept;
    assign o_waddr   = ADDR_W'({in_ch, r_ptr[in_idx]});
    assign o_raddr_a = ADDR_W'({r_ch, slot_a});
    assign o_raddr_b = ADDR_W'({r_ch, slot_b});

    always_comb begin
        o_step.valid  = (r_state == sfir_pkg::ST_RUN);
        o_step.first  = (r_k == '0);
        o_step.last   = (r_k == LAST_K);
        o_step.middle = ODD && (r_k == LAST_K);
        o_step.va     = (age_a <= r_fill[run_idx]);
        o_step.vb     = (age_b <= r_fill[run_idx]);
        o_step.k      = r_k;
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_load  = 1'b0;
        case (r_state)
            sfir_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = sfir_pkg::ST_RUN;
                end
            end
            sfir_pkg::ST_RUN: begin
                if (r_k == LAST_K) begin
                    n_state = sfir_pkg::ST_DRAIN;
                end
            end
            sfir_pkg::ST_DRAIN: begin
                if (i_done) begin
                    if (i_out_free) begin
                        o_load  = 1'b1;
                        n_state = sfir_pkg::ST_IDLE;
                    end else begin
                        n_state = sfir_pkg::ST_PUSH;
                    end
                end
            end
            sfir_pkg::ST_PUSH: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = sfir_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sfir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfir_pkg::ST_IDLE;
            r_k     <= '0;
            r_ch    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ptr[c]  <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_k  <= '0;
                r_ch <= in_ch;
            end else if (r_state == sfir_pkg::ST_RUN) begin
                r_k <= r_k + 1'b1;
                if (r_k == LAST_K) begin
                    r_ptr[run_idx] <= r_ptr[run_idx] + 1'b1;
                    if (r_fill[run_idx] != '1) begin
                        r_fill[run_idx] <= r_fill[run_idx] + 1'b1;
                    end
                end
            end
        end
    end

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == sfir_pkg::ST_RUN))
        else $error("Accepted word did not start the pair sequence.");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> i_out_free)
        else $error("Result loaded while the output register was occupied.");

    a_last_step_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_step.valid && o_step.last) |=> (r_state == sfir_pkg::ST_DRAIN))
        else $error("Pair sequence did not end after its last step.");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.valid |-> !o_ready)
        else $error("Input taken while a word is still being filtered.");

endmodule

// File: hw/rtl/sfir_mac.sv
// Folded-pair datapath: pre-add of mirrored taps, shared multiplier and the
// wrapping 32-bit accumulator. Depends on sfir_pkg.
module sfir_mac (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  sfir_pkg::t_step                                i_step,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]           i_sample,
    input  logic [sfir_pkg::SAMPLE_W-1:0]                  i_rdata_a,
    input  logic [sfir_pkg::SAMPLE_W-1:0]                  i_rdata_b,
    input  logic [sfir_pkg::NCOEF-1:0][sfir_pkg::COEF_W-1:0] i_coef,
    output logic                                           o_done,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]           o_result
);

    localparam int unsigned PAIR_W = sfir_pkg::SAMPLE_W + 1;
    localparam int unsigned PROD_W = PAIR_W + sfir_pkg::COEF_W;

    sfir_pkg::t_step r_s1;
    logic            r_p_valid;
    logic            r_p_last;
    logic            r_m_valid;
    logic            r_m_last;
    logic            r_done;

    logic signed [PAIR_W-1:0]            r_pair;
    logic signed [sfir_pkg::COEF_W-1:0]  r_coef;
    logic signed [sfir_pkg::ACC_W-1:0]   r_prod;
    logic signed [sfir_pkg::ACC_W-1:0]   r_acc;

    logic signed [sfir_pkg::SAMPLE_W-1:0] tap_a;
    logic signed [sfir_pkg::SAMPLE_W-1:0] tap_b;
    logic signed [PAIR_W-1:0]             pair;
    logic signed [PROD_W-1:0]             prod;

    always_comb begin
        if (r_s1.first) begin
            tap_a = i_sample;
        end else if (r_s1.va) begin
            tap_a = i_rdata_a;
        end else begin
            tap_a = '0;
        end
        tap_b = r_s1.vb ? i_rdata_b : '0;
        if (r_s1.middle) begin
            pair = PAIR_W'(tap_a);
        end else begin
            pair = PAIR_W'(tap_a) + PAIR_W'(tap_b);
        end
        prod = PROD_W'(r_pair) * PROD_W'(r_coef);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= '0;
            r_p_valid <= 1'b0;
            r_p_last  <= 1'b0;
            r_m_valid <= 1'b0;
            r_m_last  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_s1      <= i_step;
            r_p_valid <= r_s1.valid;
            r_p_last  <= r_s1.valid && r_s1.last;
            r_m_valid <= r_p_valid;
            r_m_last  <= r_p_last;
            r_done    <= r_m_valid && r_m_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= pair;
        r_coef <= i_coef[r_s1.k];
        r_prod <= prod[sfir_pkg::ACC_W-1:0];
        if (i_start) begin
            r_acc <= '0;
        end else if (r_m_valid) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc[sfir_pkg::ACC_W-1:sfir_pkg::ACC_W-sfir_pkg::SAMPLE_W];

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("Accumulator finished twice for one word.");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_m_valid && r_m_last))
        else $error("Done raised without a final product.");

    a_no_start_mid_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !(r_p_valid || r_m_valid))
        else $error("New word started while products were still in flight.");

endmodule

// File: hw/rtl/symmetric_fir_filter_top.sv
// Top level of the two-channel symmetric FIR filter: coefficient registers,
// input and output word registers. Depends on sfir_pkg, sfir_ram, sfir_ctl and sfir_mac.
//
//   Port group   Direction  Handshake         Word
//   input        in         i_valid/o_ready   i_data (channel, sample)
//   result       out        o_valid/i_ready   o_data (out_channel, filtered)
//   config       in         i_cfg_we          i_cfg_idx, i_cfg_wdata
//
// Each word is filtered with one delay-line RAM read pair and one multiply per folded
// pair before its result is loaded. The next word is accepted in the cycle after the
// load at the earliest, so a new word is not taken before the last one is loaded.
// Reset clears the pointers, fill counts and handshake state.
// A stalled result waits in the output register while the next word is accepted.
module symmetric_fir_filter_top #(
    parameter int unsigned TAPS     = sfir_pkg::TAPS_DEF,
    parameter int unsigned CHANNELS = sfir_pkg::CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  sfir_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output sfir_pkg::t_out                    o_data,
    input  logic                              i_cfg_we,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sfir_pkg::COEF_W-1:0]       i_cfg_wdata
);

    localparam int unsigned DEPTH  = CHANNELS * 16;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [sfir_pkg::NCOEF-1:0][sfir_pkg::COEF_W-1:0] r_coef;
    logic                                  r_in_channel;
    logic signed [sfir_pkg::SAMPLE_W-1:0]  r_sample;
    logic                                  r_out_valid;
    sfir_pkg::t_out                        r_out;

    logic                                  accept;
    logic                                  out_free;
    logic                                  load;
    logic                                  done;
    logic signed [sfir_pkg::SAMPLE_W-1:0]  result;
    logic                                  we;
    logic [ADDR_W-1:0]                     waddr;
    logic [ADDR_W-1:0]                     raddr_a;
    logic [ADDR_W-1:0]                     raddr_b;
    logic [sfir_pkg::SAMPLE_W-1:0]         rdata_a;
    logic [sfir_pkg::SAMPLE_W-1:0]         rdata_b;
    sfir_pkg::t_step                       step;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sfir_pkg::NCOEF; i++) begin
                r_coef[i] <= sfir_pkg::coef_reset(i);
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_coef[i_cfg_idx] <= i_cfg_wdata;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_channel <= i_data.channel;
            r_sample     <= i_data.sample;
        end
        if (load) begin
            r_out.out_channel <= r_in_channel;
            r_out.filtered    <= result;
        end
    end

    sfir_ctl #(
        .TAPS     (TAPS),
        .CHANNELS (CHANNELS)
    ) u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_channel  (i_data.channel),
        .i_out_free (out_free),
        .i_done     (done),
        .o_load     (load),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b),
        .o_step     (step)
    );

    sfir_ram #(
        .WIDTH (sfir_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_data.sample),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    sfir_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_step    (step),
        .i_sample  (r_sample),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .i_coef    (r_coef),
        .o_done    (done),
        .o_result  (result)
    );

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("Pending result changed before it was taken.");

    a_done_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !(r_out_valid && !i_ready))
        else $error("Result overwrote a pending word.");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !load)
        else $error("Result loaded in the cycle after acceptance.");

endmodule
